[rtl/twa_pkg.sv]
// ----------------------------------------------------------------------------
// twa_pkg: shared types and constants for the table window average block
// Field widths, divider step counts, register indexes and the sequencer
// state type.
// ----------------------------------------------------------------------------
package twa_pkg;

   localparam int IDX_W   = 12;   // table index, last_entry
   localparam int VAL_W   = 24;   // table entry, band mean (Q8.16)
   localparam int WAVE_W  = 18;   // wavelength, band width, grid start
   localparam int STEP_W  = 16;   // grid step
   localparam int PROD_W  = 28;   // last_entry * grid_step
   localparam int END_W   = 29;   // grid end wavelength
   localparam int DEN_W   = 17;   // divisor and remainder of the shared divider
   localparam int QUO_W   = 24;   // dividend / quotient shift register
   localparam int PAD_W   = 6;    // QUO_W - WAVE_W
   localparam int SUM_W   = 37;   // window sum plus rounding half
   localparam int CNT_W   = 13;   // entries in a window, up to 4096
   localparam int DSTEP_W = 5;    // divider step counter

   localparam logic [DSTEP_W-1:0] DIV_STEPS_WAVE = 5'd18;
   localparam logic [DSTEP_W-1:0] DIV_STEPS_MEAN = 5'd24;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 18;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_STEP  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_ENTRY = 2'd2;

   localparam logic [WAVE_W-1:0] GRID_START_RST = 18'd0;
   localparam logic [STEP_W-1:0] GRID_STEP_RST  = 16'd64;
   localparam logic [IDX_W-1:0]  LAST_ENTRY_RST = 12'd4095;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MULT,
      ST_RANGE,
      ST_DIV_I,
      ST_DIV_Q,
      ST_INDEX,
      ST_SUM,
      ST_DIV_M,
      ST_RESULT
   } state_type;

endpackage

[rtl/twa_ram.sv]
// ----------------------------------------------------------------------------
// twa_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module twa_ram #(
   parameter  int WIDTH  = 24,
   parameter  int DEPTH  = 4096,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/table_window_average.sv]
// ----------------------------------------------------------------------------
// table_window_average: boxcar band average over a uniform-grid value table
//
// req words (tdata/tuser, tuser = opcode): a write stores entry_value at
// entry_index and gives no result; a query gives one rsp word
// with the mean of the entries in the band around centre_wave in tdata and
// the status in tuser (1 = centre outside the grid, mean forced to zero).
// csr writes grid_start (0), grid_step (1) and last_entry (2) and drops other
// indexes; csr_ready is always high. Write it only while idle.
// Sequence: after the grid end product and the range check, a query runs the
// shared radix-2 divider for the grid index and then for the half band,
// reads the table once per entry in its window and drains the read data,
// runs the divider again for the mean and hands the result to the rsp
// register. A query outside the grid skips the divisions and the table walk.
// One query is in flight at a time; req_tready is high only when idle.
// Reset: synchronous, active high; registers return to grid_start 0, step 64,
// last_entry 4095, the table keeps its contents (no clearing pass).
// Stall: the result waits in the rsp register and a following query holds in
// its final state until that register is free.
// ----------------------------------------------------------------------------
module table_window_average #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // request words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // entry_index[11:0], entry_value[35:12],
                                   // centre_wave[53:36], band_width[71:54]
   input  logic [0:0]  req_tuser,  // opcode[0]
   // response words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // band_mean[23:0]
   output logic [0:0]  rsp_tuser,  // status[0]
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [17:0] csr_data
);

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   // Highest index the table can hold, within the 12-bit index range.
   localparam logic [11:0] LAST_MAX =
      (TABLE_DEPTH > 4096) ? 12'hFFF : 12'(TABLE_DEPTH - 1);

   // ------------------------------------------------------------------------
   // Request unpacking
   // ------------------------------------------------------------------------
   logic        req_opcode;
   logic [11:0] req_entry_index;
   logic [23:0] req_entry_value;
   logic [17:0] req_centre_wave;
   logic [17:0] req_band_width;

   assign req_opcode      = req_tuser[0];
   assign req_entry_index = req_tdata[11:0];
   assign req_entry_value = req_tdata[35:12];
   assign req_centre_wave = req_tdata[53:36];
   assign req_band_width  = req_tdata[71:54];

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [17:0] grid_start_ff;
   logic [15:0] grid_step_ff;
   logic [11:0] last_entry_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_start_ff <= twa_pkg::GRID_START_RST;
         grid_step_ff  <= twa_pkg::GRID_STEP_RST;
         last_entry_ff <= twa_pkg::LAST_ENTRY_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            twa_pkg::CSR_GRID_START: grid_start_ff <= csr_data;
            twa_pkg::CSR_GRID_STEP:  grid_step_ff  <= csr_data[15:0];
            twa_pkg::CSR_LAST_ENTRY: last_entry_ff <= csr_data[11:0];
            default: ;  // unknown register, drop the word
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer state and datapath registers
   // ------------------------------------------------------------------------
   twa_pkg::state_type state_ff, state_in;

   logic [17:0] wave_ff;
   logic [17:0] width_ff;
   logic [15:0] step_ff;      // grid step, zero taken as one
   logic [11:0] last_ff;      // last entry clamped to the table
   logic [27:0] prod_ff;      // last_entry * step
   logic        status_ff;
   logic [11:0] i_ff;         // grid index of the centre
   logic [11:0] lo_ff;
   logic [11:0] hi_ff;
   logic [11:0] rd_idx_ff;
   logic        more_ff;      // window reads still to issue
   logic        pend_ff;      // read data arriving this cycle
   logic [36:0] sum_ff;
   logic [12:0] count_ff;

   // shared restoring divider, one quotient bit per cycle
   logic [16:0] rem_ff;
   logic [23:0] quo_ff;
   logic [16:0] den_ff;
   logic [4:0]  div_cnt_ff;

   logic        rsp_tvalid_ff;
   logic [23:0] rsp_mean_ff;
   logic        rsp_status_ff;

   // ------------------------------------------------------------------------
   // Control decode
   // ------------------------------------------------------------------------
   logic req_accept;
   logic tbl_we;
   logic div_run;
   logic div_last;
   logic rd_issue;
   logic sum_done;
   logic rsp_load;

   always_comb begin
      req_tready = (state_ff == twa_pkg::ST_IDLE);
      req_accept = req_tvalid && req_tready;
      tbl_we     = req_accept && (req_opcode == twa_pkg::OP_WRITE) &&
                   (req_entry_index <= LAST_MAX);
      div_run    = (state_ff == twa_pkg::ST_DIV_I) || (state_ff == twa_pkg::ST_DIV_Q) ||
                   (state_ff == twa_pkg::ST_DIV_M);
      div_last   = div_run && (div_cnt_ff == 5'd1);
      rd_issue   = (state_ff == twa_pkg::ST_SUM) && more_ff;
      sum_done   = (state_ff == twa_pkg::ST_SUM) && !more_ff && !pend_ff;
      rsp_load   = (state_ff == twa_pkg::ST_RESULT) && (!rsp_tvalid_ff || rsp_tready);
   end

   // ------------------------------------------------------------------------
   // Combinational datapath
   // ------------------------------------------------------------------------
   logic [28:0] end_wave;
   logic        out_of_grid;
   logic [17:0] wave_diff;

   assign end_wave    = {11'd0, grid_start_ff} + {1'b0, prod_ff};
   assign out_of_grid = (wave_ff < grid_start_ff) || ({11'd0, wave_ff} > end_wave);
   assign wave_diff   = wave_ff - grid_start_ff;

   // divider step
   logic [17:0] trial;
   logic        trial_ge;
   logic [17:0] trial_sub;
   logic [16:0] rem_step;
   logic [23:0] quo_step;

   assign trial     = {rem_ff, quo_ff[23]};
   assign trial_ge  = trial >= {1'b0, den_ff};
   assign trial_sub = trial - {1'b0, den_ff};
   assign rem_step  = trial_ge ? trial_sub[16:0] : trial[16:0];
   assign quo_step  = {quo_ff[22:0], trial_ge};

   // grid index, clamped to the last entry
   logic [11:0] i_next;
   assign i_next = (quo_step[17:0] > {6'd0, last_ff}) ? last_ff : quo_step[11:0];

   // window bounds from the half band q = width / (2*step), remainder r
   logic [17:0] half_q;
   logic [18:0] hi_sum;
   logic [11:0] hi_idx;
   logic        lo_pos;
   logic        round_dn;
   logic [11:0] lo_sub;
   logic [11:0] lo_raw;
   logic [11:0] lo_idx;

   always_comb begin
      half_q   = quo_ff[17:0];
      hi_sum   = {7'd0, i_ff} + {1'b0, half_q};
      hi_idx   = (hi_sum > {7'd0, last_ff}) ? last_ff : hi_sum[11:0];
      lo_pos   = {6'd0, i_ff} > half_q;
      // r above one step pushes the rounded lower bound down by one
      round_dn = rem_ff > {1'b0, step_ff};
      lo_sub   = i_ff - half_q[11:0] - {11'd0, round_dn};
      lo_raw   = lo_pos ? lo_sub : 12'd0;
      lo_idx   = (lo_raw > hi_idx) ? hi_idx : lo_raw;
   end

   logic [23:0] rd_data;
   logic [36:0] mean_total;
   assign mean_total = sum_ff + {24'd0, 1'b0, count_ff[12:1]};

   twa_ram #(
      .WIDTH (twa_pkg::VAL_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (ADDR_W'(req_entry_index)),
      .wr_data (req_entry_value),
      .rd_en   (rd_issue),
      .rd_addr (ADDR_W'(rd_idx_ff)),
      .rd_data (rd_data)
   );

   // ------------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         twa_pkg::ST_IDLE: begin
            if (req_accept && (req_opcode == twa_pkg::OP_QUERY)) begin
               state_in = twa_pkg::ST_MULT;
            end
         end
         twa_pkg::ST_MULT:  state_in = twa_pkg::ST_RANGE;
         twa_pkg::ST_RANGE: state_in = out_of_grid ? twa_pkg::ST_RESULT : twa_pkg::ST_DIV_I;
         twa_pkg::ST_DIV_I: begin
            if (div_last) begin
               state_in = twa_pkg::ST_DIV_Q;
            end
         end
         twa_pkg::ST_DIV_Q: begin
            if (div_last) begin
               state_in = twa_pkg::ST_INDEX;
            end
         end
         twa_pkg::ST_INDEX: state_in = twa_pkg::ST_SUM;
         twa_pkg::ST_SUM: begin
            if (sum_done) begin
               state_in = twa_pkg::ST_DIV_M;
            end
         end
         twa_pkg::ST_DIV_M: begin
            if (div_last) begin
               state_in = twa_pkg::ST_RESULT;
            end
         end
         twa_pkg::ST_RESULT: begin
            if (rsp_load) begin
               state_in = twa_pkg::ST_IDLE;
            end
         end
         default: state_in = twa_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= twa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------------
   // Datapath registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      // latch the query and the effective grid settings
      if (req_accept && (req_opcode == twa_pkg::OP_QUERY)) begin
         wave_ff  <= req_centre_wave;
         width_ff <= req_band_width;
         step_ff  <= (grid_step_ff == 16'd0) ? 16'd1 : grid_step_ff;
         last_ff  <= (last_entry_ff > LAST_MAX) ? LAST_MAX : last_entry_ff;
      end

      if (state_ff == twa_pkg::ST_MULT) begin
         prod_ff <= last_entry_ff * step_ff;
      end

      // range check, then start the grid index division
      if (state_ff == twa_pkg::ST_RANGE) begin
         status_ff  <= out_of_grid;
         rem_ff     <= 17'd0;
         quo_ff     <= {wave_diff, {twa_pkg::PAD_W{1'b0}}};
         den_ff     <= {1'b0, step_ff};
         div_cnt_ff <= twa_pkg::DIV_STEPS_WAVE;
      end

      if (div_run) begin
         rem_ff     <= rem_step;
         quo_ff     <= quo_step;
         div_cnt_ff <= div_cnt_ff - 5'd1;
      end

      // grid index done: capture it and divide the band by two steps
      if ((state_ff == twa_pkg::ST_DIV_I) && div_last) begin
         i_ff       <= i_next;
         rem_ff     <= 17'd0;
         quo_ff     <= {width_ff, {twa_pkg::PAD_W{1'b0}}};
         den_ff     <= {step_ff, 1'b0};
         div_cnt_ff <= twa_pkg::DIV_STEPS_WAVE;
      end

      if (state_ff == twa_pkg::ST_INDEX) begin
         lo_ff     <= lo_idx;
         hi_ff     <= hi_idx;
         rd_idx_ff <= lo_idx;
         more_ff   <= 1'b1;
         pend_ff   <= 1'b0;
         sum_ff    <= 37'd0;
      end

      // walk the window, one read a cycle, accumulate in the cycle after each read
      if (state_ff == twa_pkg::ST_SUM) begin
         count_ff <= {1'b0, hi_ff} - {1'b0, lo_ff} + 13'd1;
         pend_ff  <= more_ff;
         if (more_ff) begin
            if (rd_idx_ff == hi_ff) begin
               more_ff <= 1'b0;
            end else begin
               rd_idx_ff <= rd_idx_ff + 12'd1;
            end
         end
         if (pend_ff) begin
            sum_ff <= sum_ff + {13'd0, rd_data};
         end
         // sum plus half the count; top bits stay below the count
         if (sum_done) begin
            rem_ff     <= {4'd0, mean_total[36:24]};
            quo_ff     <= mean_total[23:0];
            den_ff     <= {4'd0, count_ff};
            div_cnt_ff <= twa_pkg::DIV_STEPS_MEAN;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_mean_ff   <= status_ff ? 24'd0 : quo_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = rsp_mean_ff;
   assign rsp_tuser[0] = rsp_status_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
`ifndef SYNTHESIS
   a_div_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      div_run |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

   a_window_ordered: assert property (@(posedge clock) disable iff (reset)
      (state_ff == twa_pkg::ST_SUM) |-> (lo_ff <= hi_ff) && (hi_ff <= last_ff))
      else $error("window bounds out of order");

   a_read_in_window: assert property (@(posedge clock) disable iff (reset)
      rd_issue |-> (rd_idx_ff >= lo_ff) && (rd_idx_ff <= hi_ff))
      else $error("table read outside window");

   a_status_zero_mean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == 24'd0))
      else $error("out-of-grid result with nonzero mean");
`endif

endmodule

[tb/band_mean_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// band_mean_checker: result predictor and comparator for table_window_average
// Watches the register, request and response channels and keeps its own copy
// of the grid registers and the value table. For each query word it works out
// the expected band mean and status. Each response word is compared with the
// oldest expectation.
// ----------------------------------------------------------------------------
module band_mean_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [71:0]          req_tdata,
   input  logic [0:0]           req_tuser,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [23:0]          rsp_tdata,
   input  logic [0:0]           rsp_tuser,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [17:0]          csr_data,
   output int                   error_count,
   output int                   pending_count,
   output int                   checked_count
);

   localparam int DEPTH = 4096;

   typedef struct packed {
      logic [twa_pkg::VAL_W-1:0] mean;
      logic                      status;
   } band_result_type;

   logic [twa_pkg::VAL_W-1:0]  entry_store [0:DEPTH-1];
   logic [twa_pkg::WAVE_W-1:0] grid_start = twa_pkg::GRID_START_RST;
   logic [twa_pkg::STEP_W-1:0] grid_step  = twa_pkg::GRID_STEP_RST;
   logic [twa_pkg::IDX_W-1:0]  last_entry = twa_pkg::LAST_ENTRY_RST;

   band_result_type pending_means [$];
   int              fail_tally = 0;
   int              compared   = 0;

   initial begin
      for (int k = 0; k < DEPTH; k++) begin
         entry_store[k] = '0;
      end
   end

   // Boxcar mean of the entries in the band around wave, rounded to nearest.
   function automatic band_result_type band_average(
      input logic [twa_pkg::WAVE_W-1:0] wave,
      input logic [twa_pkg::WAVE_W-1:0] width);
      band_result_type   r;
      longint unsigned   stepn, lastn, end_wave, centre, span, lo, hi, sum, count, k;
      r = '0;
      stepn    = (grid_step == 0) ? 1 : longint'(grid_step);
      lastn    = (last_entry > DEPTH - 1) ? DEPTH - 1 : longint'(last_entry);
      end_wave = longint'(grid_start) + longint'(last_entry) * stepn;
      if (longint'(wave) < longint'(grid_start) || longint'(wave) > end_wave) begin
         r.status = 1'b1;
         return r;
      end
      centre = (longint'(wave) - longint'(grid_start)) / stepn;
      if (centre > lastn) begin
         centre = lastn;
      end
      span = 2 * stepn;
      // lower edge rounds half up, upper edge truncates
      if (span * centre <= longint'(width)) begin
         lo = 0;
      end else begin
         lo = (span * centre - longint'(width) + stepn) / span;
      end
      hi = centre + longint'(width) / span;
      if (hi > lastn) begin
         hi = lastn;
      end
      if (lo > hi) begin
         lo = hi;
      end
      sum = 0;
      for (k = lo; k <= hi; k++) begin
         sum += longint'(entry_store[k]);
      end
      count  = hi - lo + 1;
      sum    = (sum + count / 2) / count;
      r.mean = sum[twa_pkg::VAL_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      band_result_type want;
      if (reset) begin
         grid_start = twa_pkg::GRID_START_RST;
         grid_step  = twa_pkg::GRID_STEP_RST;
         last_entry = twa_pkg::LAST_ENTRY_RST;
         pending_means.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               twa_pkg::CSR_GRID_START: grid_start = csr_data[twa_pkg::WAVE_W-1:0];
               twa_pkg::CSR_GRID_STEP:  grid_step  = csr_data[twa_pkg::STEP_W-1:0];
               twa_pkg::CSR_LAST_ENTRY: last_entry = csr_data[twa_pkg::IDX_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_means.size() == 0) begin
               $error("unexpected result word: band_mean %h status %b",
                      rsp_tdata, rsp_tuser[0]);
               fail_tally++;
            end else begin
               want = pending_means.pop_front();
               compared++;
               if (rsp_tdata !== want.mean) begin
                  $error("band_mean: expected %h, got %h", want.mean, rsp_tdata);
                  fail_tally++;
               end
               if (rsp_tuser[0] !== want.status) begin
                  $error("status: expected %b, got %b", want.status, rsp_tuser[0]);
                  fail_tally++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == twa_pkg::OP_WRITE) begin
               if (int'(req_tdata[11:0]) < DEPTH) begin
                  entry_store[req_tdata[11:0]] = req_tdata[35:12];
               end
            end else begin
               pending_means.push_back(band_average(req_tdata[53:36], req_tdata[71:54]));
            end
         end
      end
      error_count   <= fail_tally;
      pending_count <= pending_means.size();
      checked_count <= compared;
   end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for table_window_average
// Loads table entries and sends band queries over a series of grid settings,
// with random idle gaps on the request side and random stalls on the
// response side. Every window a query can touch is written first. The
// checker beside the block predicts and compares each result word.
// ----------------------------------------------------------------------------
module tb;

   localparam int                   WAVE_MAX      = 262143;
   localparam int                   SETTLE_CYCLES = 16;
   localparam int                   TAIL_CYCLES   = 100;
   localparam int                   CYCLE_LIMIT   = 6000000;
   // index the block does not decode; writes to it must be dropped
   localparam logic [twa_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;   // entry_index[11:0], entry_value[35:12],
                             // centre_wave[53:36], band_width[71:54]
   logic [0:0]  req_tuser;   // opcode[0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // band_mean[23:0]
   logic [0:0]  rsp_tuser;   // status[0]
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [17:0] csr_data;

   int error_count;
   int pending_count;
   int checked_count;

   // stimulus-side copy of the grid registers, used to pick centres and bound windows
   logic [twa_pkg::WAVE_W-1:0] cfg_start = twa_pkg::GRID_START_RST;
   logic [twa_pkg::STEP_W-1:0] cfg_step  = twa_pkg::GRID_STEP_RST;
   logic [twa_pkg::IDX_W-1:0]  cfg_last  = twa_pkg::LAST_ENTRY_RST;

   // table entries written so far; queries never reach past these
   bit written [0:4095];

   bit steady       = 1'b0;
   int writes_sent  = 0;
   int queries_sent = 0;
   int settings     = 1;
   int cycles       = 0;

   table_window_average dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   band_mean_checker mean_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Idle length: mostly none, some short, a few long. None at all in a
   // steady stretch.
   function automatic int pick_gap();
      int r;
      if (steady) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 120);
   endfunction

   // Send one request word. Hold tvalid high when the next word follows
   // without a gap; drop it only for an idle stretch.
   task automatic push_word(input logic op, input logic [11:0] idx,
                            input logic [23:0] val, input logic [17:0] wave,
                            input logic [17:0] width);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {width, wave, val, idx};
      do @(posedge clock); while (!req_tready);
      if (op == twa_pkg::OP_WRITE) begin
         written[idx] = 1'b1;
         writes_sent++;
      end else begin
         queries_sent++;
      end
   endtask

   // Write every entry in lo..hi that has not been written yet.
   task automatic fill_span(input longint unsigned lo, input longint unsigned hi);
      longint unsigned k;
      logic [23:0]     val;
      for (k = lo; k <= hi; k++) begin
         if (!written[k]) begin
            val = ($urandom_range(0, 9) == 0) ? 24'hFFFFFF : 24'($urandom);
            push_word(twa_pkg::OP_WRITE, k[11:0], val, 18'($urandom), 18'($urandom));
         end
      end
   endtask

   // Query a band. First load any entry the window might cover: take one
   // extra entry below, since the lower edge rounds.
   task automatic ask_band(input logic [17:0] wave, input logic [17:0] width);
      longint unsigned stepn, end_wave, centre, half, lo, hi;
      stepn    = (cfg_step == 0) ? 1 : longint'(cfg_step);
      end_wave = longint'(cfg_start) + longint'(cfg_last) * stepn;
      if (wave >= cfg_start && longint'(wave) <= end_wave) begin
         centre = (longint'(wave) - longint'(cfg_start)) / stepn;
         half   = longint'(width) / (2 * stepn);
         lo     = (centre > half) ? centre - half - 1 : 0;
         hi     = centre + half;
         if (hi > cfg_last) begin
            hi = cfg_last;
         end
         fill_span(lo, hi);
      end
      push_word(twa_pkg::OP_QUERY, 12'($urandom), 24'($urandom), wave, width);
   endtask

   // Random query: some outside the grid, the rest on a random entry with a
   // band that is mostly narrow and now and then wide.
   task automatic random_band();
      longint unsigned stepn, end_wave, imax, centre, room, half, w;
      logic [17:0]     wave;
      int              pick;
      stepn    = (cfg_step == 0) ? 1 : longint'(cfg_step);
      end_wave = longint'(cfg_start) + longint'(cfg_last) * stepn;
      pick     = $urandom_range(0, 99);
      if (pick < 12 && (cfg_start > 0 || end_wave < WAVE_MAX)) begin
         if (cfg_start > 0 && (end_wave >= WAVE_MAX || $urandom_range(0, 1)))
         begin
            wave = 18'($urandom_range(0, cfg_start - 1));
         end else begin
            wave = 18'($urandom_range(32'(end_wave + 1), WAVE_MAX));
         end
         ask_band(wave, 18'($urandom));
         return;
      end
      imax = (WAVE_MAX - longint'(cfg_start)) / stepn;
      if (imax > cfg_last) begin
         imax = cfg_last;
      end
      centre = longint'($urandom_range(0, 32'(imax)));
      room   = WAVE_MAX - longint'(cfg_start) - centre * stepn;
      if (room > stepn - 1) begin
         room = stepn - 1;
      end
      wave = 18'(longint'(cfg_start) + centre * stepn +
                 longint'($urandom_range(0, 32'(room))));
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
         half = longint'($urandom_range(0, 8));
      end else if (pick < 98) begin
         half = longint'($urandom_range(9, 40));
      end else begin
         half = longint'($urandom_range(41, 160));
      end
      w = 2 * stepn * half + longint'($urandom_range(0, 32'(2 * stepn - 1)));
      if (w > WAVE_MAX) begin
         w = WAVE_MAX;
      end
      ask_band(wave, w[17:0]);
   endtask

   // Stop sending and hold until every expected result word has come.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Leaves csr_valid high; the caller drops it after the last word.
   task automatic csr_put(input logic [1:0] idx, input logic [17:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Change the grid only with the block idle. Fill the unused upper data
   // bits with noise; the block must ignore them.
   task automatic set_grid(input logic [17:0] start, input logic [15:0] stp,
                           input logic [11:0] last);
      logic [17:0] noise;
      noise = 18'($urandom);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_put(CSR_UNUSED, 18'($urandom));
      csr_put(twa_pkg::CSR_GRID_START, start);
      csr_put(twa_pkg::CSR_GRID_STEP, {noise[1:0], stp});
      csr_put(twa_pkg::CSR_LAST_ENTRY, {noise[17:12], last});
      csr_valid <= 1'b0;
      cfg_start = start;
      cfg_step  = stp;
      cfg_last  = last;
      settings++;
   endtask

   task automatic run_phase(input int budget, input bit calm);
      int stop_at, pick;
      steady  = calm;
      stop_at = writes_sent + queries_sent + budget;
      while (writes_sent + queries_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 22) begin
            push_word(twa_pkg::OP_WRITE, 12'($urandom), 24'($urandom),
                      18'($urandom), 18'($urandom));
         end else if (pick < 24) begin
            drain();
         end else begin
            random_band();
         end
      end
   endtask

   // Response side: stall at random, hold tready high in between.
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // Watchdog: end a hung run.
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: errors");
      $finish;
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset grid: extreme values at both ends of the table, a half that
      // rounds up, the last entry and a centre just past the grid end.
      push_word(twa_pkg::OP_WRITE, 12'd0,    24'h000000, 18'h3FFFF, 18'h3FFFF);
      push_word(twa_pkg::OP_WRITE, 12'd1,    24'hFFFFFF, 18'h00000, 18'h00000);
      push_word(twa_pkg::OP_WRITE, 12'd2,    24'h123456, 18'h3FFFF, 18'h00000);
      push_word(twa_pkg::OP_WRITE, 12'd4093, 24'hFFFFFF, 18'h00000, 18'h3FFFF);
      push_word(twa_pkg::OP_WRITE, 12'd4094, 24'h000000, 18'h2AAAA, 18'h15555);
      push_word(twa_pkg::OP_WRITE, 12'd4095, 24'hFFFFFF, 18'h15555, 18'h2AAAA);
      push_word(twa_pkg::OP_WRITE, 12'd2048, 24'h800000, 18'h00000, 18'h00000);
      ask_band(18'd0, 18'd0);
      ask_band(18'd63, 18'd128);
      ask_band(18'd127, 18'd64);
      ask_band(18'd262080, 18'd0);
      ask_band(18'd262079, 18'd192);
      ask_band(18'd262143, 18'd0);
      ask_band(18'd262143, 18'd262143);
      ask_band(18'd131104, 18'd0);
      ask_band(18'd131072, 18'd191);
      run_phase(500, 1'b0);

      // Zero step acts as one; centres just below and past the grid.
      set_grid(18'd100, 16'd0, 12'd40);
      ask_band(18'd99, 18'd0);
      ask_band(18'd100, 18'd0);
      ask_band(18'd140, 18'd262143);
      ask_band(18'd141, 18'd0);
      run_phase(150, 1'b1);

      // Grid starts at the top wavelength with the widest step.
      set_grid(18'd262143, 16'hFFFF, 12'hFFF);
      ask_band(18'd262143, 18'd262143);
      run_phase(40, 1'b0);

      // Smallest table: two entries.
      set_grid(18'd5000, 16'd1, 12'd1);
      ask_band(18'd5001, 18'd262143);
      ask_band(18'd5002, 18'd0);
      run_phase(100, 1'b0);

      set_grid(18'd0, 16'hFFFF, 12'hFFF);
      run_phase(120, 1'b1);

      repeat (4) begin
         set_grid(18'($urandom_range(0, 200000)), 16'($urandom_range(1, 700)),
                  12'($urandom_range(1, 4095)));
         run_phase(200, $urandom_range(0, 3) == 0);
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("tb: %0d table writes and %0d band queries over %0d grid settings",
               writes_sent, queries_sent, settings);
      $display("tb: %0d result words compared in %0d cycles", checked_count, cycles);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
